/* src/vaau_pkg.sv */
// Shared types, constants and the arctangent table of the vector axis angle unit.
package vaau_pkg;

   localparam int CORDIC_STAGES = 24;
   localparam int SQRT_STEPS    = 17;
   localparam int NORM_STEPS    = 5;

   localparam int XY_W     = 46;
   localparam int Z_W      = 34;
   localparam int M_W      = 41;
   localparam int ROOT_W   = 34;
   localparam int COMP_W   = 18;
   localparam int ROOT_OUT = 17;
   localparam int PRE_SHIFT = M_W - 32;

   localparam logic signed [Z_W-1:0]    HALF_PI_Q30 = 34'sd1686629713;
   localparam logic [30:0]              DEG_K       = 31'd961263670;
   localparam logic signed [COMP_W-1:0] ONE_Q16     = 18'sd65536;
   localparam logic [ROOT_W-1:0]        UNIT_SQ     = 34'd4294967296;

   typedef enum logic [3:0] {
      MODE_X    = 4'd0,
      MODE_X_XY = 4'd1,
      MODE_X_XZ = 4'd2,
      MODE_Y    = 4'd3,
      MODE_Y_XY = 4'd4,
      MODE_Y_YZ = 4'd5,
      MODE_Z    = 4'd6,
      MODE_Z_XZ = 4'd7,
      MODE_Z_YZ = 4'd8
   } mode_type;

   typedef logic signed [XY_W-1:0] xy_type;
   typedef logic signed [Z_W-1:0]  z_type;
   typedef logic [M_W-1:0]         mag_type;
   typedef logic [ROOT_W-1:0]      root_type;

   typedef struct packed {
      logic                     valid;
      logic                     is_axis;
      logic                     degrees;
      logic                     negate;
      logic                     zero_out;
      logic                     zero_proj;
      logic                     clamped;
      logic signed [COMP_W-1:0] comp;
      logic signed [31:0]       plane_a;
      logic [31:0]              plane_b;
   } tag_type;

   typedef struct packed {
      logic valid;
      logic degrees;
      logic negate;
      logic zero_out;
      logic zero_proj;
      logic clamped;
   } ctl_type;

   typedef struct packed {
      logic signed [31:0] angle;
      logic               zero_projection;
      logic               domain_clamped;
   } rsp_type;

   function automatic z_type atan_q30(input int idx);
      z_type t;
      case (idx)
         0:  t = 34'sd843314856;
         1:  t = 34'sd497837829;
         2:  t = 34'sd263043836;
         3:  t = 34'sd133525158;
         4:  t = 34'sd67021686;
         5:  t = 34'sd33543515;
         6:  t = 34'sd16775850;
         7:  t = 34'sd8388437;
         8:  t = 34'sd4194282;
         9:  t = 34'sd2097149;
         10: t = 34'sd1048575;
         11: t = 34'sd524287;
         12: t = 34'sd262143;
         13: t = 34'sd131071;
         14: t = 34'sd65535;
         15: t = 34'sd32767;
         16: t = 34'sd16383;
         17: t = 34'sd8191;
         18: t = 34'sd4095;
         19: t = 34'sd2047;
         20: t = 34'sd1023;
         21: t = 34'sd511;
         22: t = 34'sd255;
         23: t = 34'sd127;
         24: t = 34'sd63;
         25: t = 34'sd31;
         26: t = 34'sd15;
         27: t = 34'sd7;
         28: t = 34'sd3;
         29: t = 34'sd1;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

/* src/vaau_if.sv */
// Request and response channel interfaces of the vector axis angle unit.
interface vaau_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vec_x;
   logic signed [31:0] vec_y;
   logic signed [31:0] vec_z;
   logic [3:0]         mode;
   logic               in_degrees;

   modport source (output valid, output vec_x, output vec_y, output vec_z,
                   output mode, output in_degrees, input ready);
   modport sink (input valid, input vec_x, input vec_y, input vec_z,
                 input mode, input in_degrees, output ready);
endinterface

interface vaau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle;
   logic               zero_projection;
   logic               domain_clamped;

   modport source (output valid, output angle, output zero_projection,
                   output domain_clamped, input ready);
   modport sink (input valid, input angle, input zero_projection,
                 input domain_clamped, output ready);
endinterface

/* src/vector_axis_angle_unit.sv */
// Vector axis angle unit: angle between a Q16.16 vector and an axis, direct or
// in a projection plane, as Q9.22 radians or degrees. One request enters per
// cycle while req_ch.ready is high. Each result passes through a fully
// unrolled cell chain: a decode and a squaring register, 17 square-root
// cells, an operand select register, 5 normalization cells, one CORDIC cell
// per stage, a degree multiply register and the response register. A
// one-entry skid stage behind the response register keeps requests flowing
// while one result waits; req_ch.ready drops only while that skid entry is
// occupied. No state is kept between requests and no clearing is needed
// after reset.
module vector_axis_angle_unit (
   input logic        clock,
   input logic        reset,
   vaau_req_if.sink   req_ch,
   vaau_rsp_if.source rsp_ch
);
   import vaau_pkg::*;

   logic advance;

   // decode
   logic                     is_axis;
   logic                     is_plane;
   logic                     neg_when_low;
   logic signed [31:0]       comp;
   logic signed [31:0]       pa;
   logic signed [31:0]       po;
   logic signed [COMP_W-1:0] comp_c;
   logic                     clamped;
   logic                     zero_proj;
   tag_type                  p0_tag_ff, p0_tag_in;

   // square
   logic signed [2*COMP_W-1:0] comp_sq;
   tag_type                    p1_tag_ff;
   root_type                   p1_rem_ff, p1_rem_in;

   tag_type  sq_tag  [0:SQRT_STEPS];
   root_type sq_rem  [0:SQRT_STEPS];
   root_type sq_root [0:SQRT_STEPS];

   // operand select
   tag_type            last_tag;
   logic signed [32:0] a_sel;
   logic [31:0]        b_sel;
   logic [31:0]        xs;
   logic [31:0]        ys;
   logic [31:0]        ms;
   z_type              z0;
   ctl_type            sel_ctl_ff, sel_ctl_in;
   xy_type             sel_x_ff, sel_x_in;
   xy_type             sel_y_ff, sel_y_in;
   z_type              sel_z_ff, sel_z_in;
   mag_type            sel_m_ff, sel_m_in;

   ctl_type nm_ctl [0:NORM_STEPS];
   xy_type  nm_x   [0:NORM_STEPS];
   xy_type  nm_y   [0:NORM_STEPS];
   z_type   nm_z   [0:NORM_STEPS];
   mag_type nm_m   [0:NORM_STEPS];

   ctl_type cr_ctl [0:CORDIC_STAGES];
   xy_type  cr_x   [0:CORDIC_STAGES];
   xy_type  cr_y   [0:CORDIC_STAGES];
   z_type   cr_z   [0:CORDIC_STAGES];

   // unit conversion
   logic signed [Z_W+31-1:0] prod_in, prod_ff;
   z_type                    rad_sum;
   logic signed [31:0]       rad_in, rad_ff;
   ctl_type                  mul_ctl_ff;
   logic [31:0]              deg_val;
   logic signed [31:0]       angle_val;
   rsp_type                  tail_item;

   // response and skid
   logic    push;
   logic    pop;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   assign advance      = !skid_valid_ff;
   assign req_ch.ready = advance;

   always_comb begin
      is_axis      = 1'b0;
      is_plane     = 1'b0;
      neg_when_low = 1'b0;
      comp         = '0;
      pa           = '0;
      po           = '0;
      case (mode_type'(req_ch.mode))
         MODE_X: begin
            is_axis = 1'b1;
            comp    = req_ch.vec_x;
         end
         MODE_Y: begin
            is_axis = 1'b1;
            comp    = req_ch.vec_y;
         end
         MODE_Z: begin
            is_axis = 1'b1;
            comp    = req_ch.vec_z;
         end
         MODE_X_XY: begin
            is_plane     = 1'b1;
            pa           = req_ch.vec_x;
            po           = req_ch.vec_y;
            neg_when_low = 1'b1;
         end
         MODE_X_XZ: begin
            is_plane     = 1'b1;
            pa           = req_ch.vec_x;
            po           = req_ch.vec_z;
            neg_when_low = 1'b1;
         end
         MODE_Y_XY: begin
            is_plane = 1'b1;
            pa       = req_ch.vec_y;
            po       = req_ch.vec_x;
         end
         MODE_Y_YZ: begin
            is_plane = 1'b1;
            pa       = req_ch.vec_y;
            po       = req_ch.vec_z;
         end
         MODE_Z_XZ: begin
            is_plane = 1'b1;
            pa       = req_ch.vec_z;
            po       = req_ch.vec_x;
         end
         MODE_Z_YZ: begin
            is_plane     = 1'b1;
            pa           = req_ch.vec_z;
            po           = req_ch.vec_y;
            neg_when_low = 1'b1;
         end
         default: begin
            is_axis = 1'b0;
         end
      endcase

      clamped = 1'b0;
      comp_c  = COMP_W'(comp);
      if (comp > 32'(ONE_Q16)) begin
         comp_c  = ONE_Q16;
         clamped = is_axis;
      end else if (comp < -32'(ONE_Q16)) begin
         comp_c  = -ONE_Q16;
         clamped = is_axis;
      end
      zero_proj = is_plane && (pa == '0) && (po == '0);

      p0_tag_in           = '0;
      p0_tag_in.valid     = req_ch.valid;
      p0_tag_in.is_axis   = is_axis;
      p0_tag_in.degrees   = req_ch.in_degrees;
      p0_tag_in.negate    = is_plane && (neg_when_low ? (po < 0) : (po > 0));
      p0_tag_in.zero_out  = zero_proj || !(is_axis || is_plane);
      p0_tag_in.zero_proj = zero_proj;
      p0_tag_in.clamped   = clamped;
      p0_tag_in.comp      = comp_c;
      p0_tag_in.plane_a   = pa;
      p0_tag_in.plane_b   = po[31] ? $unsigned(-po) : $unsigned(po);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_tag_ff.valid <= 1'b0;
      end else if (advance) begin
         p0_tag_ff <= p0_tag_in;
      end
   end

   assign comp_sq   = p0_tag_ff.comp * p0_tag_ff.comp;
   assign p1_rem_in = UNIT_SQ - ROOT_W'(comp_sq);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_tag_ff.valid <= 1'b0;
      end else if (advance) begin
         p1_tag_ff <= p0_tag_ff;
         p1_rem_ff <= p1_rem_in;
      end
   end

   assign sq_tag[0]  = p1_tag_ff;
   assign sq_rem[0]  = p1_rem_ff;
   assign sq_root[0] = '0;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam root_type BIT_K = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      vaau_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .bit_val (BIT_K),
         .up_tag  (sq_tag[k]),
         .up_rem  (sq_rem[k]),
         .up_root (sq_root[k]),
         .dn_tag  (sq_tag[k+1]),
         .dn_rem  (sq_rem[k+1]),
         .dn_root (sq_root[k+1])
      );
   end

   always_comb begin
      last_tag = sq_tag[SQRT_STEPS];
      a_sel    = last_tag.is_axis ? 33'(last_tag.comp) : 33'(last_tag.plane_a);
      b_sel    = last_tag.is_axis ? 32'(sq_root[SQRT_STEPS][ROOT_OUT-1:0])
                                  : last_tag.plane_b;
      if (a_sel < 0) begin
         xs = b_sel;
         ys = 32'(-a_sel);
         z0 = HALF_PI_Q30;
      end else begin
         xs = a_sel[31:0];
         ys = b_sel;
         z0 = '0;
      end
      ms = (xs > ys) ? xs : ys;

      sel_ctl_in.valid     = last_tag.valid;
      sel_ctl_in.degrees   = last_tag.degrees;
      sel_ctl_in.negate    = last_tag.negate;
      sel_ctl_in.zero_out  = last_tag.zero_out;
      sel_ctl_in.zero_proj = last_tag.zero_proj;
      sel_ctl_in.clamped   = last_tag.clamped;
      sel_x_in             = xy_type'(xs) <<< PRE_SHIFT;
      sel_y_in             = xy_type'(ys) <<< PRE_SHIFT;
      sel_z_in             = z0;
      sel_m_in             = mag_type'(ms) << PRE_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         sel_ctl_ff <= sel_ctl_in;
         sel_x_ff   <= sel_x_in;
         sel_y_ff   <= sel_y_in;
         sel_z_ff   <= sel_z_in;
         sel_m_ff   <= sel_m_in;
      end
   end

   assign nm_ctl[0] = sel_ctl_ff;
   assign nm_x[0]   = sel_x_ff;
   assign nm_y[0]   = sel_y_ff;
   assign nm_z[0]   = sel_z_ff;
   assign nm_m[0]   = sel_m_ff;

   for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
      localparam logic [4:0] STEP_K = 5'(1 << (NORM_STEPS - 1 - k));
      vaau_norm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .step    (STEP_K),
         .up_ctl  (nm_ctl[k]),
         .up_x    (nm_x[k]),
         .up_y    (nm_y[k]),
         .up_z    (nm_z[k]),
         .up_m    (nm_m[k]),
         .dn_ctl  (nm_ctl[k+1]),
         .dn_x    (nm_x[k+1]),
         .dn_y    (nm_y[k+1]),
         .dn_z    (nm_z[k+1]),
         .dn_m    (nm_m[k+1])
      );
   end

   assign cr_ctl[0] = nm_ctl[NORM_STEPS];
   assign cr_x[0]   = nm_x[NORM_STEPS];
   assign cr_y[0]   = nm_y[NORM_STEPS];
   assign cr_z[0]   = nm_z[NORM_STEPS];

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      localparam logic [4:0] SHIFT_K = 5'(k);
      localparam z_type      ATAN_K  = atan_q30(k);
      vaau_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .shift    (SHIFT_K),
         .atan_val (ATAN_K),
         .up_ctl   (cr_ctl[k]),
         .up_x     (cr_x[k]),
         .up_y     (cr_y[k]),
         .up_z     (cr_z[k]),
         .dn_ctl   (cr_ctl[k+1]),
         .dn_x     (cr_x[k+1]),
         .dn_y     (cr_y[k+1]),
         .dn_z     (cr_z[k+1])
      );
   end

   assign prod_in = cr_z[CORDIC_STAGES] * $signed({1'b0, DEG_K});
   assign rad_sum = cr_z[CORDIC_STAGES] + z_type'(128);
   assign rad_in  = 32'(rad_sum >>> 8);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         mul_ctl_ff <= cr_ctl[CORDIC_STAGES];
         prod_ff    <= prod_in;
         rad_ff     <= rad_in;
      end
   end

   always_comb begin
      deg_val   = prod_ff[63:32] + 32'(prod_ff[31]);
      angle_val = mul_ctl_ff.degrees ? $signed(deg_val) : rad_ff;
      if (mul_ctl_ff.negate) begin
         angle_val = -angle_val;
      end
      if (mul_ctl_ff.zero_out) begin
         angle_val = '0;
      end
      tail_item.angle           = angle_val;
      tail_item.zero_projection = mul_ctl_ff.zero_proj;
      tail_item.domain_clamped  = mul_ctl_ff.clamped;
   end

   assign push = advance && mul_ctl_ff.valid;
   assign pop  = rsp_valid_ff && rsp_ch.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = tail_item;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = tail_item;
         end
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.angle           = rsp_data_ff.angle;
   assign rsp_ch.zero_projection = rsp_data_ff.zero_projection;
   assign rsp_ch.domain_clamped  = rsp_data_ff.domain_clamped;

endmodule

/* src/vaau_sqrt_cell.sv */
// One root bit of the digit-by-digit square root chain.
module vaau_sqrt_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  vaau_pkg::root_type       bit_val,
   input  vaau_pkg::tag_type        up_tag,
   input  vaau_pkg::root_type       up_rem,
   input  vaau_pkg::root_type       up_root,
   output vaau_pkg::tag_type        dn_tag,
   output vaau_pkg::root_type       dn_rem,
   output vaau_pkg::root_type       dn_root
);
   import vaau_pkg::*;

   tag_type  tag_ff,  tag_in;
   root_type rem_ff,  rem_in;
   root_type root_ff, root_in;
   root_type trial;

   assign trial = up_root + bit_val;

   always_comb begin
      tag_in  = up_tag;
      rem_in  = up_rem;
      root_in = up_root >> 1;
      if (up_rem >= trial) begin
         rem_in  = up_rem - trial;
         root_in = (up_root >> 1) + bit_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (advance) begin
         tag_ff  <= tag_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dn_tag  = tag_ff;
   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;

endmodule

/* src/vaau_norm_cell.sv */
// One conditional left-shift step of the operand normalization chain.
module vaau_norm_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [4:0]        step,
   input  vaau_pkg::ctl_type up_ctl,
   input  vaau_pkg::xy_type  up_x,
   input  vaau_pkg::xy_type  up_y,
   input  vaau_pkg::z_type   up_z,
   input  vaau_pkg::mag_type up_m,
   output vaau_pkg::ctl_type dn_ctl,
   output vaau_pkg::xy_type  dn_x,
   output vaau_pkg::xy_type  dn_y,
   output vaau_pkg::z_type   dn_z,
   output vaau_pkg::mag_type dn_m
);
   import vaau_pkg::*;

   ctl_type    ctl_ff, ctl_in;
   xy_type     x_ff, x_in;
   xy_type     y_ff, y_in;
   z_type      z_ff, z_in;
   mag_type    m_ff, m_in;
   logic [5:0] keep;
   mag_type    top_bits;

   assign keep     = 6'(M_W) - {1'b0, step};
   assign top_bits = up_m >> keep;

   always_comb begin
      ctl_in = up_ctl;
      z_in   = up_z;
      x_in   = up_x;
      y_in   = up_y;
      m_in   = up_m;
      if (top_bits == '0) begin
         x_in = up_x <<< step;
         y_in = up_y <<< step;
         m_in = up_m << step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         m_ff   <= m_in;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_x   = x_ff;
   assign dn_y   = y_ff;
   assign dn_z   = z_ff;
   assign dn_m   = m_ff;

endmodule

/* src/vaau_cordic_cell.sv */
// One CORDIC vectoring iteration with its pipeline register.
module vaau_cordic_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [4:0]        shift,
   input  vaau_pkg::z_type   atan_val,
   input  vaau_pkg::ctl_type up_ctl,
   input  vaau_pkg::xy_type  up_x,
   input  vaau_pkg::xy_type  up_y,
   input  vaau_pkg::z_type   up_z,
   output vaau_pkg::ctl_type dn_ctl,
   output vaau_pkg::xy_type  dn_x,
   output vaau_pkg::xy_type  dn_y,
   output vaau_pkg::z_type   dn_z
);
   import vaau_pkg::*;

   ctl_type ctl_ff, ctl_in;
   xy_type  x_ff, x_in;
   xy_type  y_ff, y_in;
   z_type   z_ff, z_in;
   xy_type  dx;
   xy_type  dy;

   assign dx = up_y >>> shift;
   assign dy = up_x >>> shift;

   always_comb begin
      ctl_in = up_ctl;
      if (!up_y[XY_W-1]) begin
         x_in = up_x + dx;
         y_in = up_y - dy;
         z_in = up_z + atan_val;
      end else begin
         x_in = up_x - dx;
         y_in = up_y + dy;
         z_in = up_z - atan_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_x   = x_ff;
   assign dn_y   = y_ff;
   assign dn_z   = z_ff;

endmodule

/* src/vaau_checker.sv */
// Port-level checks of the vector axis angle unit and their binding.
module vaau_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_angle,
   input logic               rsp_zero_projection,
   input logic               rsp_domain_clamped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_zero_proj_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_projection |-> rsp_angle == 32'sd0)
      else $error("zero projection with nonzero angle");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_zero_projection && rsp_domain_clamped))
      else $error("plane and axis flags both set");

endmodule

bind vector_axis_angle_unit vaau_checker u_vaau_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_angle           (rsp_ch.angle),
   .rsp_zero_projection (rsp_ch.zero_projection),
   .rsp_domain_clamped  (rsp_ch.domain_clamped)
);

/* tb/vector_axis_angle_unit_tb.sv */
// Self-checking testbench of the vector axis angle unit: directed table, then random requests.
`timescale 1ns / 1ps

module vector_axis_angle_unit_tb;
   import vaau_pkg::*;

   localparam logic [3:0]         MODE_SPARE_LO = 4'd9;
   localparam logic [3:0]         MODE_SPARE_HI = 4'd15;
   localparam logic signed [31:0] POS_FULL      = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] NEG_FULL      = 32'sh8000_0000;
   localparam logic signed [31:0] UNIT          = 32'sd65536;
   localparam longint             UNIT_Q16      = 64'sd65536;
   localparam longint             QUARTER_TURN  = 64'sd1686629713;
   localparam longint             DEG_SCALE     = 64'sd961263670;
   localparam int                 RANDOM_COUNT  = 1626;
   localparam int                 DRAIN_CYCLES  = 60;
   localparam rsp_type            ANGLE_NONE    = '{32'sd0, 1'b0, 1'b0};
   localparam rsp_type            PROJ_ZERO     = '{32'sd0, 1'b1, 1'b0};

   localparam longint ARCTAN_Q30 [32] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
      15, 7, 3, 1, 0, 0
   };

   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic [3:0]         mode;
      logic               degrees;
      logic               typed;
      rsp_type            want;
   } probe_type;

   localparam int PROBE_COUNT = 24;
   localparam probe_type PROBES [PROBE_COUNT] = '{
      '{UNIT, 32'sd0, 32'sd0, MODE_X, 1'b0, 1'b0, ANGLE_NONE},
      '{-UNIT, 32'sd0, 32'sd0, MODE_X, 1'b1, 1'b0, ANGLE_NONE},
      '{POS_FULL, 32'sd7, 32'sd0, MODE_X, 1'b1, 1'b0, ANGLE_NONE},
      '{NEG_FULL, 32'sd0, 32'sd0, MODE_X, 1'b0, 1'b0, ANGLE_NONE},
      '{32'sd0, 32'sd65537, 32'sd0, MODE_Y, 1'b0, 1'b0, ANGLE_NONE},
      '{32'sd0, 32'sd0, -32'sd65537, MODE_Z, 1'b1, 1'b0, ANGLE_NONE},
      '{32'sd0, 32'sd0, 32'sd0, MODE_Z, 1'b0, 1'b0, ANGLE_NONE},
      '{32'sd0, 32'sd0, POS_FULL, MODE_X_XY, 1'b0, 1'b1, PROJ_ZERO},
      '{32'sd0, 32'sd5, 32'sd0, MODE_X_XZ, 1'b1, 1'b1, PROJ_ZERO},
      '{32'sd0, 32'sd0, NEG_FULL, MODE_Y_XY, 1'b0, 1'b1, PROJ_ZERO},
      '{NEG_FULL, 32'sd0, 32'sd0, MODE_Y_YZ, 1'b1, 1'b1, PROJ_ZERO},
      '{32'sd0, POS_FULL, 32'sd0, MODE_Z_XZ, 1'b0, 1'b1, PROJ_ZERO},
      '{POS_FULL, 32'sd0, 32'sd0, MODE_Z_YZ, 1'b1, 1'b1, PROJ_ZERO},
      '{NEG_FULL, NEG_FULL, 32'sd0, MODE_X_XY, 1'b1, 1'b0, ANGLE_NONE},
      '{POS_FULL, POS_FULL, 32'sd0, MODE_X_XY, 1'b0, 1'b0, ANGLE_NONE},
      '{32'sd1, 32'sd0, -32'sd1, MODE_X_XZ, 1'b1, 1'b0, ANGLE_NONE},
      '{32'sd100, -32'sd1, 32'sd0, MODE_Y_XY, 1'b0, 1'b0, ANGLE_NONE},
      '{32'sd0, NEG_FULL, 32'sd1, MODE_Y_YZ, 1'b1, 1'b0, ANGLE_NONE},
      '{32'sd0, 32'sd0, -32'sd5, MODE_Z_XZ, 1'b0, 1'b0, ANGLE_NONE},
      '{32'sd0, NEG_FULL, 32'sd0, MODE_Z_YZ, 1'b1, 1'b0, ANGLE_NONE},
      '{UNIT, UNIT, UNIT, MODE_SPARE_LO, 1'b0, 1'b1, ANGLE_NONE},
      '{NEG_FULL, POS_FULL, NEG_FULL, MODE_SPARE_HI, 1'b1, 1'b1, ANGLE_NONE},
      '{NEG_FULL, 32'sd0, POS_FULL, MODE_X_XZ, 1'b1, 1'b0, ANGLE_NONE},
      '{32'sd0, POS_FULL, 32'sd0, MODE_Y_YZ, 1'b0, 1'b0, ANGLE_NONE}
   };

   logic clock;
   logic reset;

   vaau_req_if req_bus ();
   vaau_rsp_if rsp_bus ();

   vector_axis_angle_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   rsp_type pending_angles[$];
   int      mismatches = 0;
   int      req_calm   = 0;
   int      rsp_calm   = 0;
   int      rsp_stall  = 0;

   initial clock = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_600_000;
      $display("vector_axis_angle_unit: mismatch");
      $finish;
   end

   function automatic int idle_length(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm = $urandom_range(20, 120);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [31:0] pick_component();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom_range(0, 1) ? POS_FULL : NEG_FULL;
         2: return ($urandom_range(0, 1) ? UNIT : -UNIT)
                   + $signed(32'($urandom_range(0, 4))) - 32'sd2;
         3, 4, 5: return $signed(32'($urandom_range(0, 131072))) - UNIT;
         default: return $signed(32'($urandom()));
      endcase
   endfunction

   function automatic rsp_type predict_angle(input logic signed [31:0] vx, vy, vz,
                                             input logic [3:0] mode, input logic degrees);
      rsp_type          r;
      longint           comp [3];
      longint           a, b, other, x, y, z, m, dx, dy, turn;
      longint unsigned  n, root, probe;
      logic             axis, plane, flip_negative, negate, run;
      int               ax, ot, i;
      r = ANGLE_NONE;
      comp[0] = vx;
      comp[1] = vy;
      comp[2] = vz;
      axis = 1'b0;
      plane = 1'b0;
      flip_negative = 1'b0;
      negate = 1'b0;
      run = 1'b0;
      ax = 0;
      ot = 0;
      a = 0;
      b = 0;
      case (mode)
         MODE_X, MODE_Y, MODE_Z: axis = 1'b1;
         MODE_X_XY: begin plane = 1'b1; ax = 0; ot = 1; flip_negative = 1'b1; end
         MODE_X_XZ: begin plane = 1'b1; ax = 0; ot = 2; flip_negative = 1'b1; end
         MODE_Y_XY: begin plane = 1'b1; ax = 1; ot = 0; end
         MODE_Y_YZ: begin plane = 1'b1; ax = 1; ot = 2; end
         MODE_Z_XZ: begin plane = 1'b1; ax = 2; ot = 0; end
         MODE_Z_YZ: begin plane = 1'b1; ax = 2; ot = 1; flip_negative = 1'b1; end
         default: ;
      endcase
      if (axis) begin
         a = comp[mode / 3];
         if (a > UNIT_Q16) begin
            a = UNIT_Q16;
            r.domain_clamped = 1'b1;
         end
         if (a < -UNIT_Q16) begin
            a = -UNIT_Q16;
            r.domain_clamped = 1'b1;
         end
         n = UNIT_Q16 * UNIT_Q16 - a * a;
         root = 0;
         probe = 64'd1 << 62;
         while (probe > n) probe = probe >> 2;
         while (probe != 0) begin
            if (n >= root + probe) begin
               n = n - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         b = longint'(root);
         run = 1'b1;
      end
      if (plane) begin
         a = comp[ax];
         other = comp[ot];
         negate = flip_negative ? (other < 0) : (other > 0);
         if (a == 0 && other == 0) begin
            r.zero_projection = 1'b1;
         end else begin
            b = other < 0 ? -other : other;
            run = 1'b1;
         end
      end
      if (run) begin
         x = a;
         y = b;
         z = 0;
         if (x < 0) begin
            x = b;
            y = -a;
            z = QUARTER_TURN;
         end
         m = x > y ? x : y;
         while (m < (64'sd1 <<< 40)) begin
            x = x <<< 1;
            y = y <<< 1;
            m = m <<< 1;
         end
         for (i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               z = z + (i < 32 ? ARCTAN_Q30[i] : 64'sd0);
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - (i < 32 ? ARCTAN_Q30[i] : 64'sd0);
            end
         end
         if (degrees) turn = (z * DEG_SCALE + (64'sd1 <<< 31)) >>> 32;
         else turn = (z + 64'sd128) >>> 8;
         if (negate) turn = -turn;
         r.angle = turn[31:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("%0t ns %s: got %0d, want %0d", $time, field, got, want);
      mismatches++;
   endtask

   task automatic send_request(input logic signed [31:0] vx, vy, vz, input logic [3:0] mode,
                               input logic degrees, input rsp_type want);
      int gap;
      gap = idle_length(req_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.vec_x      <= vx;
      req_bus.vec_y      <= vy;
      req_bus.vec_z      <= vz;
      req_bus.mode       <= mode;
      req_bus.in_degrees <= degrees;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_angles.push_back(want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_angles.size() == 0) begin
            report_mismatch("response with no request", rsp_bus.angle, 0);
         end else begin
            want = pending_angles.pop_front();
            if (rsp_bus.angle !== want.angle)
               report_mismatch("angle", rsp_bus.angle, want.angle);
            if (rsp_bus.zero_projection !== want.zero_projection)
               report_mismatch("zero_projection", rsp_bus.zero_projection,
                               want.zero_projection);
            if (rsp_bus.domain_clamped !== want.domain_clamped)
               report_mismatch("domain_clamped", rsp_bus.domain_clamped,
                               want.domain_clamped);
         end
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= (rsp_stall == 0);
      end else begin
         rsp_stall = idle_length(rsp_calm);
         rsp_bus.ready <= (rsp_stall == 0);
      end
   end

   initial begin
      logic signed [31:0] vx, vy, vz;
      logic [3:0]         mode;
      logic               degrees;
      probe_type          p;
      int                 roll;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.vec_x      <= '0;
      req_bus.vec_y      <= '0;
      req_bus.vec_z      <= '0;
      req_bus.mode       <= MODE_X;
      req_bus.in_degrees <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < PROBE_COUNT; k++) begin
         p = PROBES[k];
         send_request(p.vx, p.vy, p.vz, p.mode, p.degrees,
                      p.typed ? p.want : predict_angle(p.vx, p.vy, p.vz, p.mode, p.degrees));
      end

      repeat (RANDOM_COUNT) begin
         vx = pick_component();
         vy = pick_component();
         vz = pick_component();
         roll = $urandom_range(0, 99);
         if (roll < 4) mode = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         else mode = 4'($urandom_range(MODE_X, MODE_Z_YZ));
         degrees = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: begin vx = '0; vy = '0; end
               1: begin vx = '0; vz = '0; end
               default: begin vy = '0; vz = '0; end
            endcase
         end
         send_request(vx, vy, vz, mode, degrees, predict_angle(vx, vy, vz, mode, degrees));
      end
      req_bus.valid <= 1'b0;

      while (pending_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("vector_axis_angle_unit: match");
      end else begin
         $display("vector_axis_angle_unit: mismatch");
      end
      $finish;
   end

endmodule

/* files.f */
src/vaau_pkg.sv
src/vaau_if.sv
src/vaau_sqrt_cell.sv
src/vaau_norm_cell.sv
src/vaau_cordic_cell.sv
src/vector_axis_angle_unit.sv
src/vaau_checker.sv
tb/vector_axis_angle_unit_tb.sv
